// File: hdl/hst_pkg.sv
// Shared types and constants for the hash slot key table.
package hst_pkg;

    localparam int KEY_W          = 34;
    localparam int NAME_W         = 64;
    localparam int SLOT_W         = 4;
    localparam int HOME_W         = 6;    // holds a home slot for tables up to 64 slots
    localparam int KEY_IDX_W      = $clog2(KEY_W);
    localparam int MOD_STEP       = 7;    // key bits folded into the residue per stage
    localparam int MOD_STAGES     = (KEY_W + MOD_STEP - 1) / MOD_STEP;
    localparam int TABLE_SLOTS_DEF = 16;
    localparam int DATA_W         = 104;
    localparam int S_USER_W       = 2;
    localparam int M_USER_W       = 3;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_COLLISION = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // command travelling down the chain
    typedef struct packed {
        logic                vld;
        t_op                 op;
        logic [KEY_W-1:0]    key;
        logic [NAME_W-1:0]   name;
        logic [SLOT_W-1:0]   slot;
        logic [HOME_W-1:0]   home;
    } t_token;

    // partial result travelling beside the command
    typedef struct packed {
        logic                done;
        t_status             status;
        logic [SLOT_W-1:0]   index;
        logic                e_valid;
        logic [KEY_W-1:0]    e_key;
        logic [NAME_W-1:0]   e_name;
    } t_result;

endpackage

// File: hdl/hst_mod_stage.sv
// One stage of the key mod table-size reduction, a few key bits per stage.
module hst_mod_stage #(
    parameter int TABLE_SLOTS = hst_pkg::TABLE_SLOTS_DEF,
    parameter int STAGE       = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  hst_pkg::t_token i_tok,
    output hst_pkg::t_token o_tok
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W:0] RES_N = (IDX_W + 1)'(TABLE_SLOTS);

    hst_pkg::t_token n_tok;
    hst_pkg::t_token r_tok;

    // restoring reduction, MSB first: r = (2r + bit) mod N
    always_comb begin
        logic [IDX_W:0] r;
        int             b;
        n_tok = i_tok;
        r     = {1'b0, i_tok.home[IDX_W-1:0]};
        for (int j = 0; j < hst_pkg::MOD_STEP; j++) begin
            b = hst_pkg::KEY_W - 1 - (STAGE * hst_pkg::MOD_STEP + j);
            if (b >= 0) begin
                r = {r[IDX_W-1:0], i_tok.key[b[hst_pkg::KEY_IDX_W-1:0]]};
                if (r >= RES_N) begin
                    r = r - RES_N;
                end
            end
        end
        n_tok.home = hst_pkg::HOME_W'(r[IDX_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: hdl/hst_cell.sv
// One table slot: holds a record and acts on each command passing through.
module hst_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  hst_pkg::t_token  i_tok,
    input  hst_pkg::t_result i_res,
    output hst_pkg::t_token  o_tok,
    output hst_pkg::t_result o_res
);

    localparam logic [hst_pkg::HOME_W-1:0] MY_HOME = hst_pkg::HOME_W'(CELL_IDX);
    localparam logic [hst_pkg::SLOT_W-1:0] MY_IDX  = hst_pkg::SLOT_W'(CELL_IDX);

    logic                       r_valid;
    logic [hst_pkg::KEY_W-1:0]  r_key;
    logic [hst_pkg::NAME_W-1:0] r_name;

    hst_pkg::t_token  r_tok;
    hst_pkg::t_result r_res;
    hst_pkg::t_result n_res;

    logic hit;
    logic wr;
    logic clr;

    assign hit = r_valid && (r_key == i_tok.key);

    always_comb begin
        n_res = i_res;
        wr    = 1'b0;
        clr   = 1'b0;
        if (i_tok.vld && !i_res.done) begin
            case (i_tok.op)
                hst_pkg::OP_INSERT: begin
                    if (i_tok.home == MY_HOME) begin
                        n_res.done    = 1'b1;
                        n_res.index   = MY_IDX;
                        n_res.e_valid = 1'b1;
                        if (r_valid) begin
                            n_res.status = hst_pkg::ST_COLLISION;
                            n_res.e_key  = r_key;
                            n_res.e_name = r_name;
                        end else begin
                            n_res.status = hst_pkg::ST_DONE;
                            n_res.e_key  = i_tok.key;
                            n_res.e_name = i_tok.name;
                            wr           = 1'b1;
                        end
                    end
                end
                hst_pkg::OP_SEARCH: begin
                    if (hit) begin
                        n_res.done    = 1'b1;
                        n_res.status  = hst_pkg::ST_DONE;
                        n_res.index   = MY_IDX;
                        n_res.e_valid = 1'b1;
                        n_res.e_key   = r_key;
                        n_res.e_name  = r_name;
                    end
                end
                hst_pkg::OP_DELETE: begin
                    if (hit) begin
                        n_res.done    = 1'b1;
                        n_res.status  = hst_pkg::ST_DONE;
                        n_res.index   = MY_IDX;
                        n_res.e_valid = 1'b0;
                        n_res.e_key   = '0;
                        n_res.e_name  = '0;
                        clr           = 1'b1;
                    end
                end
                hst_pkg::OP_READ: begin
                    if (hst_pkg::HOME_W'(i_tok.slot) == MY_HOME) begin
                        n_res.done    = 1'b1;
                        n_res.status  = hst_pkg::ST_DONE;
                        n_res.index   = MY_IDX;
                        n_res.e_valid = r_valid;
                        n_res.e_key   = r_valid ? r_key  : '0;
                        n_res.e_name  = r_valid ? r_name : '0;
                    end
                end
                default: begin
                    n_res = i_res;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            if (wr) begin
                r_valid <= 1'b1;
            end else if (clr) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && wr) begin
            r_key  <= i_tok.key;
            r_name <= i_tok.name;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_en) begin
            r_tok <= i_tok;
            r_res <= n_res;
        end
    end

    assign o_tok = r_tok;
    assign o_res = r_res;

endmodule

// File: hdl/hash_slot_key_table.sv
// Top level of the hash slot key table: a keyed record table built as a chain of slot cells.
//
// Usage:
//   Commands enter on the s_axis channel, one transaction per command: tuser carries the
//   operation (insert, search, delete, read slot), tdata the key, name and slot.
//   Each command yields exactly one result transaction on m_axis: tuser carries status
//   and entry valid, tdata the slot index, stored key and stored name.
//   Insert writes slot key mod TABLE_SLOTS if it is empty, else reports a collision.
//   Search and delete find the lowest valid slot holding the key; delete then clears it.
//   Read slot returns the contents of one slot, or not found past the table end.
// Timing:
//   A command first runs through MOD_STAGES reduction stages (five for a 34-bit key)
//   that form its home slot, then through one cell per slot, then the output register.
//   The chain is systolic: a new command can enter every cycle unless the output is
//   stalled, and since each cell sees commands in arrival order the results match a
//   one-at-a-time table exactly.
// Reset and stall:
//   Reset empties the table (all slot valid bits clear) and drops commands in flight.
//   When the output is stalled the whole chain holds and s_axis tready goes low.
module hash_slot_key_table #(
    parameter int TABLE_SLOTS = hst_pkg::TABLE_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [hst_pkg::DATA_W-1:0]   i_s_axis_tdata,  // key[33:0], name[97:34], slot[101:98]
    input  logic [hst_pkg::S_USER_W-1:0] i_s_axis_tuser,  // operation[1:0]
    // result channel
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [hst_pkg::DATA_W-1:0]   o_m_axis_tdata,  // index[3:0], key[37:4], name[101:38]
    output logic [hst_pkg::M_USER_W-1:0] o_m_axis_tuser   // status[1:0], entry_valid[2]
);

    localparam int NSTG = hst_pkg::MOD_STAGES;
    localparam int PW   = hst_pkg::DATA_W - hst_pkg::SLOT_W - hst_pkg::KEY_W
                          - hst_pkg::NAME_W;

    // whole chain advances together when the output register can take a result
    logic en;

    hst_pkg::t_token  w_tok [0:NSTG+TABLE_SLOTS];
    hst_pkg::t_result w_res [0:TABLE_SLOTS];

    hst_pkg::t_token  last_tok;
    hst_pkg::t_result last_res;

    logic                       r_out_valid;
    hst_pkg::t_status           r_out_status;
    logic [hst_pkg::SLOT_W-1:0] r_out_index;
    logic                       r_out_evalid;
    logic [hst_pkg::KEY_W-1:0]  r_out_key;
    logic [hst_pkg::NAME_W-1:0] r_out_name;

    hst_pkg::t_status           n_out_status;
    logic [hst_pkg::SLOT_W-1:0] n_out_index;
    logic                       n_out_evalid;
    logic [hst_pkg::KEY_W-1:0]  n_out_key;
    logic [hst_pkg::NAME_W-1:0] n_out_name;

    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // unpack the command; residue starts at zero
    always_comb begin
        w_tok[0].vld  = i_s_axis_tvalid;
        w_tok[0].op   = hst_pkg::t_op'(i_s_axis_tuser);
        w_tok[0].key  = i_s_axis_tdata[hst_pkg::KEY_W-1:0];
        w_tok[0].name = i_s_axis_tdata[hst_pkg::KEY_W +: hst_pkg::NAME_W];
        w_tok[0].slot = i_s_axis_tdata[hst_pkg::KEY_W+hst_pkg::NAME_W +: hst_pkg::SLOT_W];
        w_tok[0].home = '0;
    end

    assign w_res[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NSTG; g++) begin : g_mod
            hst_mod_stage #(
                .TABLE_SLOTS (TABLE_SLOTS),
                .STAGE       (g)
            ) u_mod (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
        for (g = 0; g < TABLE_SLOTS; g++) begin : g_cell
            hst_cell #(
                .CELL_IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_tok   (w_tok[NSTG+g]),
                .i_res   (w_res[g]),
                .o_tok   (w_tok[NSTG+g+1]),
                .o_res   (w_res[g+1])
            );
        end
    endgenerate

    assign last_tok = w_tok[NSTG+TABLE_SLOTS];
    assign last_res = w_res[TABLE_SLOTS];

    // pass on the claiming cell's result, else not found (search/delete miss, read past end)
    always_comb begin
        if (last_res.done) begin
            n_out_status = last_res.status;
            n_out_index  = last_res.index;
            n_out_evalid = last_res.e_valid;
            n_out_key    = last_res.e_key;
            n_out_name   = last_res.e_name;
        end else begin
            n_out_status = hst_pkg::ST_NOT_FOUND;
            n_out_index  = (last_tok.op == hst_pkg::OP_READ) ? last_tok.slot : '0;
            n_out_evalid = 1'b0;
            n_out_key    = '0;
            n_out_name   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last_tok.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_status <= n_out_status;
            r_out_index  <= n_out_index;
            r_out_evalid <= n_out_evalid;
            r_out_key    <= n_out_key;
            r_out_name   <= n_out_name;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PW{1'b0}}, r_out_name, r_out_key, r_out_index};
    assign o_m_axis_tuser  = {r_out_evalid, r_out_status};

    // an insert always reaches its home cell
    a_insert_claimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (last_tok.vld && last_tok.op == hst_pkg::OP_INSERT) |-> last_res.done)
        else $error("insert left the chain without reaching its home slot");

    // a miss carries an empty entry
    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == hst_pkg::ST_NOT_FOUND)
        |-> (!r_out_evalid && r_out_key == '0 && r_out_name == '0))
        else $error("not-found result carries entry data");

    // a collision reports the occupying record
    a_collision_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == hst_pkg::ST_COLLISION) |-> r_out_evalid)
        else $error("collision reported on an empty slot");

endmodule
